// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// File: design/mbpsx_pkg.sv
// Shared types and constants of the MIDI byte parser.
package mbpsx_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VID_FIRST  = 2'd0,
    REG_VID_SECOND = 2'd1,
    REG_VID_THIRD  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_REALTIME = 3'd1,
    EV_CHANNEL  = 3'd2,
    EV_PARAM    = 3'd3,
    EV_COMMIT   = 3'd4,
    EV_ERROR    = 3'd5
  } event_e;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONT     = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;
  localparam logic [3:0] KIND_PROG     = 4'hC;
  localparam logic [3:0] KIND_PRESSURE = 4'hD;
  localparam logic [3:0] KIND_SYSTEM   = 4'hF;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
    logic [6:0] third;
  } vid_t;

  typedef struct packed {
    event_e     ev;
    logic [7:0] status;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [6:0] param_high;
    logic [6:0] param_low;
    logic [6:0] value_high;
    logic [6:0] value_low;
  } res_t;

endpackage

// File: design/mbpsx_core.sv
// Parser state and per-byte decode: running status, data gathering, sysex phases.
module mbpsx_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             lockout_i,
  input  mbpsx_pkg::vid_t  vid_i,
  output mbpsx_pkg::res_t  res_o
);
  import mbpsx_pkg::*;

  typedef enum logic [3:0] {
    PH_NONE   = 4'd0,
    PH_IGNORE = 4'd1,
    PH_ID0    = 4'd2,
    PH_ID1    = 4'd3,
    PH_ID2    = 4'd4,
    PH_PARH   = 4'd5,
    PH_PARL   = 4'd6,
    PH_VALH   = 4'd7,
    PH_VALL   = 4'd8
  } phase_e;

  logic [7:0] rs_q, rs_d;
  logic [1:0] exp_q, exp_d;
  logic [1:0] rcv_q, rcv_d;
  logic [6:0] data0_q, data0_d;
  logic [6:0] data1_q, data1_d;
  phase_e     phase_q, phase_d;
  logic [6:0] ph_q, ph_d;
  logic [6:0] pl_q, pl_d;
  logic [6:0] vh_q, vh_d;

  logic [6:0] b7;
  logic [1:0] rcv_inc;
  logic [3:0] rs_kind;

  assign b7      = rx_byte_i[6:0];
  assign rcv_inc = rcv_q + 2'd1;
  assign rs_kind = rs_q[7:4];

  always_comb begin
    rs_d    = rs_q;
    exp_d   = exp_q;
    rcv_d   = rcv_q;
    data0_d = data0_q;
    data1_d = data1_q;
    phase_d = phase_q;
    ph_d    = ph_q;
    pl_d    = pl_q;
    vh_d    = vh_q;
    res_o   = '0;
    res_o.ev = EV_NONE;

    if (lockout_i) begin
      rs_d = '0;
    end else if (rx_byte_i[7:4] == KIND_SYSTEM) begin
      unique case (rx_byte_i)
        RT_CLOCK, RT_START, RT_CONT, RT_STOP: begin
          res_o.ev     = EV_REALTIME;
          res_o.status = rx_byte_i;
        end
        ST_MTC, ST_SONG_POS, ST_SONG_SEL: begin
          rcv_d = '0;
          rs_d  = rx_byte_i;
          exp_d = (rx_byte_i == ST_SONG_POS) ? 2'd2 : 2'd1;
        end
        ST_SYSEX: begin
          phase_d = PH_ID0;
        end
        ST_EOX: begin
          if (phase_q == PH_PARH) begin
            res_o.ev = EV_COMMIT;
          end else if (phase_q != PH_NONE && phase_q != PH_IGNORE) begin
            res_o.ev = EV_ERROR;
          end
          phase_d = PH_NONE;
        end
        default: ;
      endcase
    end else if (rx_byte_i[7]) begin
      phase_d = PH_NONE;
      rcv_d   = '0;
      rs_d    = rx_byte_i;
      exp_d   = (rx_byte_i[7:4] == KIND_PROG || rx_byte_i[7:4] == KIND_PRESSURE)
                ? 2'd1 : 2'd2;
    end else begin
      unique case (phase_q)
        PH_ID0:  phase_d = (b7 == vid_i.first)  ? PH_ID1  : PH_IGNORE;
        PH_ID1:  phase_d = (b7 == vid_i.second) ? PH_ID2  : PH_IGNORE;
        PH_ID2:  phase_d = (b7 == vid_i.third)  ? PH_PARH : PH_IGNORE;
        PH_PARH: begin
          ph_d    = b7;
          phase_d = PH_PARL;
        end
        PH_PARL: begin
          pl_d    = b7;
          phase_d = PH_VALH;
        end
        PH_VALH: begin
          vh_d    = b7;
          phase_d = PH_VALL;
        end
        PH_VALL: begin
          res_o.ev         = EV_PARAM;
          res_o.param_high = ph_q;
          res_o.param_low  = pl_q;
          res_o.value_high = vh_q;
          res_o.value_low  = b7;
          phase_d          = PH_PARH;
        end
        PH_NONE: begin
          if (rs_q != '0) begin
            if (rcv_q[0]) begin
              data1_d = b7;
            end else begin
              data0_d = b7;
            end
            rcv_d = rcv_inc;
            if (rcv_inc >= exp_q) begin
              rcv_d = '0;
              if (rs_kind == KIND_NOTE_OFF || rs_kind == KIND_NOTE_ON ||
                  rs_kind == KIND_CTRL || rs_kind == KIND_PROG) begin
                res_o.ev          = EV_CHANNEL;
                res_o.status      = rs_q;
                res_o.first_data  = data0_d;
                res_o.second_data = data1_d;
              end
            end
          end
        end
        default: ;  // ignoring rest of a foreign sysex block
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q    <= '0;
      exp_q   <= '0;
      rcv_q   <= '0;
      data0_q <= '0;
      data1_q <= '0;
      phase_q <= PH_NONE;
      ph_q    <= '0;
      pl_q    <= '0;
      vh_q    <= '0;
    end else if (acc_i) begin
      rs_q    <= rs_d;
      exp_q   <= exp_d;
      rcv_q   <= rcv_d;
      data0_q <= data0_d;
      data1_q <= data1_d;
      phase_q <= phase_d;
      ph_q    <= ph_d;
      pl_q    <= pl_d;
      vh_q    <= vh_d;
    end
  end

endmodule

// File: design/midi_byte_parser_with_sysex_params_unit.sv
// Top level of the MIDI byte parser with sysex parameter writes.
//
// Input channel: in_valid_i / in_stall_o carry rx_byte_i and lockout_i; one
// byte is taken at each edge where valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry one result item for every
// byte taken (event_res_o = none when the byte completes nothing).
// Config channel: cfg_valid_i / cfg_ready_o write the three manufacturer ID
// bytes by index; ready is always high, unused indexes are dropped.
// Result: each byte's result is registered, into the result register or,
// when the output stalls, the skid register. Throughput: one byte per cycle
// while in_stall_o is low, set by the combinational decode ahead of them.
// Stall: a two-entry output stage (result register plus skid register) lets
// one more byte in after the receiver stalls; in_stall_o then rises, driven
// only by the skid register, and the held result does not change.
// Reset: all parser state, ID registers and both output entries clear; the
// first byte can be taken right after reset is released.
module midi_byte_parser_with_sysex_params_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        lockout_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  event_res_o,
  output logic [7:0]                  status_out_o,
  output logic [6:0]                  first_data_o,
  output logic [6:0]                  second_data_o,
  output logic [6:0]                  param_high_o,
  output logic [6:0]                  param_low_o,
  output logic [6:0]                  value_high_o,
  output logic [6:0]                  value_low_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mbpsx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [6:0]                  cfg_data_i
);
  import mbpsx_pkg::*;
  `include "assert_macros.svh"

  vid_t vid_q;
  res_t res_new;
  res_t out_q;
  res_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;
  logic in_acc;
  logic out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vid_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VID_FIRST:  vid_q.first  <= cfg_data_i;
        REG_VID_SECOND: vid_q.second <= cfg_data_i;
        REG_VID_THIRD:  vid_q.third  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  mbpsx_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (in_acc),
    .rx_byte_i (rx_byte_i),
    .lockout_i (lockout_i),
    .vid_i     (vid_q),
    .res_o     (res_new)
  );

  // result register with a skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_q        <= skid_q;
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_q       <= res_new;
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_q       <= res_new;
      skid_valid_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = out_q.ev;
  assign status_out_o  = out_q.status;
  assign first_data_o  = out_q.first_data;
  assign second_data_o = out_q.second_data;
  assign param_high_o  = out_q.param_high;
  assign param_low_o   = out_q.param_low;
  assign value_high_o  = out_q.value_high;
  assign value_low_o   = out_q.value_low;

  `ASSERT_NEVER(a_skid_needs_out, clk_i, rst_ni, skid_valid_q && !out_valid_q)
  `ASSERT_CLK(a_held_result_kept, clk_i, rst_ni, out_valid_q && out_stall_i |=> out_valid_q)
  `ASSERT_CLK(a_empty_event_zero, clk_i, rst_ni,
              out_valid_q && out_q.ev == EV_NONE |->
              out_q.status == '0 && out_q.first_data == '0 && out_q.value_low == '0)

endmodule
